/* hw/rtl/pws_pkg.sv */
package pws_pkg;

	localparam int unsigned NUM_PLANTS = 4;
	localparam int unsigned PLANT_W = 2;

	localparam int unsigned IN_DATA_W = 8;
	localparam int unsigned OUT_DATA_W = 32;
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [31:0] ILLUM_POLL = 32'd5;
	localparam logic [31:0] HUMID_POLL = 32'd5;
	localparam logic [31:0] WATER_POLL = 32'd20;

	localparam logic [15:0] RST_INTERVAL = 16'd60;
	localparam logic [15:0] RST_TICKS_PER_SEC = 16'd100;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_START_THR = 3'd0,
		REG_STOP_THR  = 3'd1,
		REG_NI_MASK   = 3'd2,
		REG_INTERVAL  = 3'd3,
		REG_TICKS     = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		LOG_NONE       = 2'd0,
		LOG_WATER_ON   = 2'd1,
		LOG_WATER_DONE = 2'd2
	} log_event_t;

	typedef enum logic [9:0] {
		ST_START       = 10'b00_0000_0001,
		ST_HANDLE      = 10'b00_0000_0010,
		ST_MEAS_ILLUM  = 10'b00_0000_0100,
		ST_CHECK_ILLUM = 10'b00_0000_1000,
		ST_MEAS_HUMID  = 10'b00_0001_0000,
		ST_CHECK_HUMID = 10'b00_0010_0000,
		ST_WATER_ON    = 10'b00_0100_0000,
		ST_CHECK_WATER = 10'b00_1000_0000,
		ST_NEXT        = 10'b01_0000_0000,
		ST_END         = 10'b10_0000_0000
	} step_t;

endpackage

/* hw/rtl/plant_watering_sequencer.sv */
// Plant watering sequencer.
// Every beat on the s_axis channel is one scheduler tick carrying the sensor
// ready flag (tuser) and the sensor reading (tdata). Each accepted tick
// produces exactly one result beat on m_axis with the measurement start,
// pump level, log event, per-plant record (flagged by tuser) and the end of
// round marker (tlast).
// The sequencer walks the plants in order, skips the ones masked as not
// installed, measures illumination and humidity, waters until the stop
// threshold is met and waits the configured number of seconds between rounds.
// The result of a tick is registered and valid right after the edge that
// accepts it. Throughput is one tick per cycle while the receiver keeps up;
// the state update, a 16x16 multiply for the round wait and a byte compare
// sit between the state registers and the result register.
// When the receiver stalls, the result register holds and s_axis_tready
// drops until that beat is taken; a new tick is accepted in the same cycle
// the waiting result leaves.
// The cfg channel is always ready and should only be written while idle.
// Reset starts a new round on the first tick, with default interval 60 s at
// 100 ticks per second and all thresholds and the skip mask at zero.
module plant_watering_sequencer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [pws_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // [7:0] sensor_value
	input  logic [0:0]                          s_axis_tuser,  // [0] sensor_ready
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [1:0] plant_index, [2] measure_start, [3] measure_humidity, [4] pump_on,
	// [6:5] log_event, [14:7] rec_illumination, [22:15] rec_humidity,
	// [23] rec_not_installed, [24] busy_res, [31:25] zero
	output logic [pws_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	output logic [0:0]                          m_axis_tuser,  // [0] plant_done
	output logic                                m_axis_tlast,  // record_done
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pws_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [pws_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import pws_pkg::*;

	logic [31:0] start_thr_q;
	logic [31:0] stop_thr_q;
	logic [NUM_PLANTS-1:0] ni_mask_q;
	logic [15:0] interval_q;
	logic [15:0] ticks_q;

	step_t step_q, nx_step;
	logic [PLANT_W-1:0] plant_q, nx_plant;
	logic [31:0] wait_q, nx_wait;
	logic [7:0] illum_q, nx_illum;

	logic in_acc;
	logic sensor_ready;
	logic [7:0] sensor_value;
	logic [7:0] start_thr;
	logic [7:0] stop_thr;
	logic [31:0] round_wait;
	logic [PLANT_W:0] plant_inc;

	logic r_meas_start, r_meas_humid, r_plant_done, r_ni, r_rec_done;
	log_event_t r_log;
	logic [7:0] r_illum, r_humid;

	logic out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic out_user_q;
	logic out_last_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_thr_q <= '0;
			stop_thr_q  <= '0;
			ni_mask_q   <= '0;
			interval_q  <= RST_INTERVAL;
			ticks_q     <= RST_TICKS_PER_SEC;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_START_THR: start_thr_q <= cfg_data;
				REG_STOP_THR:  stop_thr_q  <= cfg_data;
				REG_NI_MASK:   ni_mask_q   <= cfg_data[NUM_PLANTS-1:0];
				REG_INTERVAL:  interval_q  <= cfg_data[15:0];
				REG_TICKS:     ticks_q     <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign sensor_ready  = s_axis_tuser[0];
	assign sensor_value  = s_axis_tdata[7:0];

	assign start_thr  = start_thr_q[{plant_q, 3'b000} +: 8];
	assign stop_thr   = stop_thr_q[{plant_q, 3'b000} +: 8];
	assign round_wait = ticks_q * interval_q;
	assign plant_inc  = {1'b0, plant_q} + 1'b1;

	always_comb begin
		nx_step      = step_q;
		nx_plant     = plant_q;
		nx_wait      = wait_q;
		nx_illum     = illum_q;
		r_meas_start = 1'b0;
		r_meas_humid = 1'b0;
		r_log        = LOG_NONE;
		r_plant_done = 1'b0;
		r_illum      = '0;
		r_humid      = '0;
		r_ni         = 1'b0;
		r_rec_done   = 1'b0;
		if (wait_q > 32'd1) begin
			nx_wait = wait_q - 32'd1;
		end else begin
			nx_wait = '0;
			case (step_q)
				ST_START: begin
					nx_plant = '0;
					nx_step  = ST_HANDLE;
				end
				ST_HANDLE: begin
					if (ni_mask_q[plant_q]) begin
						r_plant_done = 1'b1;
						r_ni         = 1'b1;
						nx_step      = ST_NEXT;
					end else begin
						nx_step = ST_MEAS_ILLUM;
					end
				end
				ST_MEAS_ILLUM: begin
					r_meas_start = 1'b1;
					nx_step      = ST_CHECK_ILLUM;
					nx_wait      = ILLUM_POLL;
				end
				ST_CHECK_ILLUM: begin
					if (!sensor_ready) begin
						nx_wait = ILLUM_POLL;
					end else begin
						nx_illum = sensor_value;
						nx_step  = ST_MEAS_HUMID;
					end
				end
				ST_MEAS_HUMID: begin
					r_meas_start = 1'b1;
					r_meas_humid = 1'b1;
					nx_step      = ST_CHECK_HUMID;
					nx_wait      = HUMID_POLL;
				end
				ST_CHECK_HUMID: begin
					if (!sensor_ready) begin
						nx_wait = HUMID_POLL;
					end else if (sensor_value < start_thr) begin
						nx_step = ST_WATER_ON;
					end else begin
						r_plant_done = 1'b1;
						r_illum      = illum_q;
						r_humid      = sensor_value;
						nx_step      = ST_NEXT;
					end
				end
				ST_WATER_ON: begin
					r_meas_start = 1'b1;
					r_meas_humid = 1'b1;
					r_log        = LOG_WATER_ON;
					nx_step      = ST_CHECK_WATER;
					nx_wait      = WATER_POLL;
				end
				ST_CHECK_WATER: begin
					if (!sensor_ready || sensor_value < stop_thr) begin
						nx_wait = WATER_POLL;
					end else begin
						r_log        = LOG_WATER_DONE;
						r_plant_done = 1'b1;
						r_illum      = illum_q;
						r_humid      = sensor_value;
						nx_step      = ST_NEXT;
					end
				end
				ST_NEXT: begin
					if (plant_inc >= (PLANT_W+1)'(NUM_PLANTS)) begin
						nx_plant = '0;
						nx_step  = ST_END;
					end else begin
						nx_plant = plant_inc[PLANT_W-1:0];
						nx_step  = ST_HANDLE;
					end
				end
				ST_END: begin
					r_rec_done = 1'b1;
					nx_step    = ST_START;
					nx_wait    = round_wait;
				end
				default: begin
					nx_step = ST_START;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= ST_START;
			plant_q <= '0;
			wait_q  <= '0;
			illum_q <= '0;
		end else if (in_acc) begin
			step_q  <= nx_step;
			plant_q <= nx_plant;
			wait_q  <= nx_wait;
			illum_q <= nx_illum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload of the result beat; the pump level and busy flag follow the
	// state after this tick's action.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			out_data_q <= {7'd0,
				(nx_step != ST_START),
				r_ni,
				r_humid,
				r_illum,
				r_log,
				(nx_step == ST_CHECK_WATER),
				r_meas_humid,
				r_meas_start,
				nx_plant};
			out_user_q <= r_plant_done;
			out_last_q <= r_rec_done;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = out_data_q;
	assign m_axis_tuser[0] = out_user_q;
	assign m_axis_tlast    = out_last_q;

	a_pump_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[24])
		else $error("pump on outside a busy round");

	a_round_end_plant: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[1:0] == '0 && !m_axis_tuser[0])
		else $error("round end beat carries a plant record");

	a_wait_after_round: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && step_q == ST_END && wait_q <= 32'd1 |=> wait_q == $past(round_wait))
		else $error("round wait not loaded at the end of a round");

	a_water_start: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[6:5] == LOG_WATER_ON
		|-> m_axis_tdata[2] && m_axis_tdata[3] && m_axis_tdata[4])
		else $error("watering start without humidity measurement and pump");

	a_skip_record: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[23] |-> m_axis_tuser[0] && m_axis_tdata[22:7] == '0)
		else $error("skipped plant record carries readings");

	a_stall_no_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(step_q) && $stable(wait_q))
		else $error("sequencer advanced while the result beat was stalled");

endmodule
